@@ rtl/core/clocked_serial_frame_receiver_defines.svh @@
// assertion macros for the serial frame receiver checker
// no dependencies; included by files that hold concurrent assertions
`ifndef CLOCKED_SERIAL_FRAME_RECEIVER_DEFINES_SVH
`define CLOCKED_SERIAL_FRAME_RECEIVER_DEFINES_SVH

// same-cycle implication, clocked on aclk, quiet in reset
`define SRX_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on aclk, quiet in reset
`define SRX_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication that is also checked while reset is low
`define SRX_ASSERT_RESET(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/srx_pkg.sv @@
// shared types and constants for the serial frame receiver
// no dependencies
`default_nettype none

package srx_pkg;

    localparam int unsigned DataW     = 8;
    localparam int unsigned IndexW    = 7;
    localparam int unsigned LenW      = 6;
    localparam int unsigned OverheadW = 5;
    localparam int unsigned PosW      = 4;

    localparam logic [PosW-1:0]      ParityPos       = PosW'(9);
    localparam logic [PosW-1:0]      FirstDataPos    = PosW'(1);
    localparam logic [IndexW-1:0]    LengthByteIndex = IndexW'(1);
    localparam logic [OverheadW-1:0] OverheadReset   = OverheadW'(3);

    localparam int unsigned STdataW = 8;
    localparam int unsigned MTdataW = 16;
    localparam int unsigned MTuserW = 2;

    typedef struct packed {
        logic [DataW-1:0]  data_byte;
        logic [IndexW-1:0] byte_index;
        logic              parity_bad;
        logic              frame_has_error;
        logic              frame_last;
    } srx_result_t;

endpackage

`default_nettype wire

@@ rtl/core/srx_in_reg.sv @@
// input register: holds one line sample until the frame logic takes it
// depends on srx_pkg
`default_nettype none

module srx_in_reg (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [srx_pkg::STdataW-1:0] s_tdata,
    input  wire logic                        take,
    output logic                             sample_valid,
    output logic                             sample_bit
);
    import srx_pkg::*;

    logic valid_reg;
    logic valid_next;
    logic bit_reg;

    // free slot, or the held sample leaves this cycle
    assign s_tready = !valid_reg || take;

    always_comb begin
        valid_next = valid_reg;
        if (s_tready) begin
            valid_next = s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (s_tready && s_tvalid) begin
            bit_reg <= s_tdata[0];
        end
    end

    assign sample_valid = valid_reg;
    assign sample_bit   = bit_reg;

endmodule

`default_nettype wire

@@ rtl/core/srx_core.sv @@
// frame state: start detect, byte assembly, parity and frame counting
// depends on srx_pkg
`default_nettype none

module srx_core (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            step,
    input  wire logic                            sample_bit,
    input  wire logic [srx_pkg::OverheadW-1:0]   frame_overhead,
    output logic                                 at_parity,
    output logic                                 emit,
    output srx_pkg::srx_result_t                 result
);
    import srx_pkg::*;

    logic                 receiving_reg,  receiving_next;
    logic [PosW-1:0]      pos_reg,        pos_next;
    logic [DataW-1:0]     shift_reg,      shift_next;
    logic [IndexW-1:0]    bytes_done_reg, bytes_done_next;
    logic [LenW-1:0]      length_reg,     length_next;
    logic                 error_reg,      error_next;

    logic                 parity_bad;
    logic [LenW-1:0]      length_now;
    logic [IndexW:0]      count;
    logic [IndexW:0]      bound;
    logic                 last;
    logic                 err_now;

    assign at_parity = receiving_reg && (pos_reg == ParityPos);
    assign emit      = step && at_parity;

    // odd parity: data ones plus parity bit must be odd
    assign parity_bad = sample_bit != ~(^shift_reg);
    assign err_now    = error_reg | parity_bad;
    assign length_now = (bytes_done_reg == LengthByteIndex) ? shift_reg[LenW-1:0]
                                                            : length_reg;
    assign count = {1'b0, bytes_done_reg} + (IndexW+1)'(1);
    assign bound = (IndexW+1)'(length_now) + (IndexW+1)'(frame_overhead);
    assign last  = count >= bound;

    always_comb begin
        receiving_next  = receiving_reg;
        pos_next        = pos_reg;
        shift_next      = shift_reg;
        bytes_done_next = bytes_done_reg;
        length_next     = length_reg;
        error_next      = error_reg;
        if (step) begin
            priority if (!receiving_reg) begin
                if (!sample_bit) begin
                    receiving_next = 1'b1;
                    pos_next       = FirstDataPos;
                    shift_next     = '0;
                end
            end else if (pos_reg != ParityPos) begin
                // lsb first: eight right shifts leave bit 0 at the bottom
                shift_next = {sample_bit, shift_reg[DataW-1:1]};
                pos_next   = pos_reg + PosW'(1);
            end else begin
                receiving_next = 1'b0;
                pos_next       = '0;
                if (last) begin
                    bytes_done_next = '0;
                    length_next     = '0;
                    error_next      = 1'b0;
                end else begin
                    bytes_done_next = count[IndexW-1:0];
                    length_next     = length_now;
                    error_next      = err_now;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            receiving_reg  <= 1'b0;
            pos_reg        <= '0;
            shift_reg      <= '0;
            bytes_done_reg <= '0;
            length_reg     <= '0;
            error_reg      <= 1'b0;
        end else begin
            receiving_reg  <= receiving_next;
            pos_reg        <= pos_next;
            shift_reg      <= shift_next;
            bytes_done_reg <= bytes_done_next;
            length_reg     <= length_next;
            error_reg      <= error_next;
        end
    end

    always_comb begin
        result.data_byte       = shift_reg;
        result.byte_index      = bytes_done_reg;
        result.parity_bad      = parity_bad;
        result.frame_has_error = err_now;
        result.frame_last      = last;
    end

endmodule

`default_nettype wire

@@ rtl/core/srx_out_reg.sv @@
// result register on the output stream
// depends on srx_pkg
`default_nettype none

module srx_out_reg (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        load,
    input  wire srx_pkg::srx_result_t        result,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [srx_pkg::MTdataW-1:0]      m_tdata,
    output logic [srx_pkg::MTuserW-1:0]      m_tuser,
    output logic                             m_tlast
);
    import srx_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    srx_result_t data_reg;

    always_comb begin
        valid_next = valid_reg;
        if (m_tready) begin
            valid_next = 1'b0;
        end
        if (load) begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (load) begin
            data_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {1'b0, data_reg.byte_index, data_reg.data_byte};
    assign m_tuser  = {data_reg.frame_has_error, data_reg.parity_bad};
    assign m_tlast  = data_reg.frame_last;

endmodule

`default_nettype wire

@@ rtl/core/clocked_serial_frame_receiver.sv @@
// top level of the serial frame receiver: input register, frame logic, result register
// depends on srx_pkg, srx_in_reg, srx_core, srx_out_reg
//
//  channel | dir | tdata (lsb up)              | tuser (lsb up)              | tlast
//  s_      | in  | rx_bit, 7 zero bits         | -                           | -
//  m_      | out | data_byte, byte_index, zero | parity_bad, frame_has_error | frame_last
//  cfg_    | in  | frame_overhead (5 bits) on cfg_wr_data, written when cfg_wr_en is high
//
// one sample taken per cycle while s_tready is high; a sample reaches the frame logic in the
// cycle after it is taken, and a completed byte appears on m_ in the cycle after its parity
// sample is processed. a byte takes ten samples, so at most one result per ten samples.
// reset (aresetn low, synchronous) empties both registers, idles the frame logic and
// sets frame_overhead to 3. s_tready drops only while a parity sample waits behind an
// unaccepted result.
`default_nettype none

module clocked_serial_frame_receiver (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [srx_pkg::OverheadW-1:0] cfg_wr_data,   // frame_overhead
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [srx_pkg::STdataW-1:0]   s_tdata,       // [0] rx_bit, [7:1] zero
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [srx_pkg::MTdataW-1:0]        m_tdata,  // [7:0] data_byte, [14:8] byte_index
    output logic [srx_pkg::MTuserW-1:0]        m_tuser,  // [0] parity_bad, [1] frame_has_error
    output logic                               m_tlast        // frame_last
);
    import srx_pkg::*;

    logic [OverheadW-1:0] overhead_reg;
    logic                 sample_valid;
    logic                 sample_bit;
    logic                 at_parity;
    logic                 blocked;
    logic                 step;
    logic                 emit;
    srx_result_t          result;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            overhead_reg <= OverheadReset;
        end else if (cfg_wr_en) begin
            overhead_reg <= cfg_wr_data;
        end
    end

    // a parity sample cannot proceed while the result register is still full
    assign blocked = at_parity && m_tvalid && !m_tready;
    assign step    = sample_valid && !blocked;

    srx_in_reg u_in_reg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .take         (step),
        .sample_valid (sample_valid),
        .sample_bit   (sample_bit)
    );

    srx_core u_core (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .step           (step),
        .sample_bit     (sample_bit),
        .frame_overhead (overhead_reg),
        .at_parity      (at_parity),
        .emit           (emit),
        .result         (result)
    );

    srx_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (emit),
        .result   (result),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

@@ rtl/core/srx_checker.sv @@
// port-level checks on the result stream of the serial frame receiver
// depends on srx_pkg and clocked_serial_frame_receiver_defines.svh; bound to the top level
`default_nettype none

`include "clocked_serial_frame_receiver_defines.svh"

module srx_checker (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        m_tvalid,
    input  wire logic                        m_tready,
    input  wire logic [srx_pkg::MTdataW-1:0] m_tdata,
    input  wire logic [srx_pkg::MTuserW-1:0] m_tuser,
    input  wire logic                        m_tlast
);
    import srx_pkg::*;

    // a stalled request keeps its contents
    `SRX_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "result changed while stalled")

    // the sticky flag covers this byte's own parity error
    `SRX_ASSERT_NOW(a_sticky_covers, m_tvalid && m_tuser[0], m_tuser[1], "parity error without frame error")

    // first byte of a frame has no earlier bytes to carry an error from
    `SRX_ASSERT_NOW(a_first_byte_err, m_tvalid && (m_tdata[14:8] == 7'd0), m_tuser[1] == m_tuser[0], "frame error on first byte without parity error")

    // reset empties the result register
    `SRX_ASSERT_RESET(a_reset_empty, !aresetn, !m_tvalid, "result valid after reset")

endmodule

bind clocked_serial_frame_receiver srx_checker u_srx_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire
